>>> rtl/tds_pkg.sv
package tds_pkg;

    localparam int DATA_W       = 32;
    localparam int IDX_W        = 6;
    localparam int MAX_ROWS_DEF = 64;
    localparam int FRAC_DEF     = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL1,
        ST_MUL1_W,
        ST_MUL2,
        ST_MUL2_W,
        ST_DIVP,
        ST_DIVP_W,
        ST_DIVQ,
        ST_DIVQ_W,
        ST_WR,
        ST_EMIT,
        ST_BRD,
        ST_BMUL,
        ST_BMUL_W
    } state_t;

    // clamp a sum that has grown by one bit back into the data range
    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W:0] s);
        logic [DATA_W-1:0] r;
        if (s[DATA_W] == s[DATA_W-1]) begin
            r = s[DATA_W-1:0];
        end else if (s[DATA_W]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> rtl/tds_ram.sv
module tds_ram #(
    parameter int WIDTH = tds_pkg::DATA_W,
    parameter int DEPTH = tds_pkg::MAX_ROWS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/tds_mul.sv
module tds_mul #(
    parameter int FRAC_BITS = tds_pkg::FRAC_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tds_pkg::DATA_W-1:0]  x,
    input  logic [tds_pkg::DATA_W-1:0]  y,
    output logic                        done,
    output logic [tds_pkg::DATA_W-1:0]  result
);

    localparam int DW    = tds_pkg::DATA_W;
    localparam int ACC_W = 2 * DW;
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    xm_reg, xm_next;
    logic [ACC_W-1:0] prod_reg, prod_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             fin_reg, fin_next;
    logic             done_reg, done_next;
    logic [DW-1:0]    res_reg, res_next;

    logic [DW:0]             hi;
    logic signed [ACC_W-1:0] sp, rnd, sh;

    always_comb begin
        xm_next   = xm_reg;
        prod_next = prod_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        res_next  = res_reg;
        hi = {1'b0, prod_reg[ACC_W-1:DW]} + (prod_reg[0] ? {1'b0, xm_reg} : '0);
        sp  = neg_reg ? -$signed(prod_reg) : $signed(prod_reg);
        rnd = sp + (ACC_W'(1) << (FRAC_BITS - 1));
        sh  = rnd >>> FRAC_BITS;
        if (start) begin
            // magnitudes, one multiplier bit a cycle
            xm_next   = x[DW-1] ? DW'(-x) : x;
            prod_next = {{DW{1'b0}}, (y[DW-1] ? DW'(-y) : y)};
            neg_next  = x[DW-1] ^ y[DW-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prod_next = {hi, prod_reg[DW-1:1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            done_next = 1'b1;
            if (sh[ACC_W-1:DW-1] == '0 || sh[ACC_W-1:DW-1] == '1) begin
                res_next = sh[DW-1:0];
            end else if (sh[ACC_W-1]) begin
                res_next = {1'b1, {(DW-1){1'b0}}};
            end else begin
                res_next = {1'b0, {(DW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        xm_reg   <= xm_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> rtl/tds_div.sv
module tds_div #(
    parameter int FRAC_BITS = tds_pkg::FRAC_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tds_pkg::DATA_W-1:0]  num_mag,
    input  logic                        num_neg,
    input  logic [tds_pkg::DATA_W-1:0]  den,
    output logic                        done,
    output logic [tds_pkg::DATA_W-1:0]  result
);

    localparam int DW    = tds_pkg::DATA_W;
    localparam int NW    = DW + 1 + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    dm_reg, dm_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic             zero_reg, zero_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             fin_reg, fin_next;
    logic             done_reg, done_next;
    logic [DW-1:0]    res_reg, res_next;

    logic [DW-1:0] dmag;
    logic [DW:0]   trial;
    logic          qbit;
    logic          big;
    logic [DW-1:0] mag;

    always_comb begin
        dm_next   = dm_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        res_next  = res_reg;
        dmag  = den[DW-1] ? DW'(-den) : den;
        trial = {rem_reg, n_reg[NW-1]};
        qbit  = trial >= {1'b0, dm_reg};
        big   = (|n_reg[NW-1:DW]) || (n_reg[DW-1] && (|n_reg[DW-2:0]));
        mag   = big ? {1'b1, {(DW-1){1'b0}}} : n_reg[DW-1:0];
        if (start) begin
            // half the divisor added up front rounds to nearest
            dm_next   = dmag;
            n_next    = NW'({num_mag, {FRAC_BITS{1'b0}}}) + NW'(dmag >> 1);
            rem_next  = '0;
            neg_next  = num_neg ^ den[DW-1];
            zero_next = (den == '0);
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? DW'(trial - {1'b0, dm_reg}) : trial[DW-1:0];
            n_next   = {n_reg[NW-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NW - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            done_next = 1'b1;
            if (zero_reg) begin
                res_next = '0;
            end else if (neg_reg) begin
                res_next = DW'(-mag);
            end else if (mag[DW-1]) begin
                res_next = {1'b0, {(DW-1){1'b1}}};
            end else begin
                res_next = mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dm_reg   <= dm_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> rtl/tridiagonal_system_solver.sv
// channel | ports                                              | direction
// rows    | s_valid s_ready s_sub_diag s_diag s_super_diag     | in
//         | s_rhs s_last_row                                   |
// results | m_valid m_ready m_solution m_row_index m_singular   | out
//         | m_last_result                                      |
// one row item at a time; each row uses the bit-serial multiplier twice and, unless
// the pivot is zero, the bit-serial divider twice
// back substitution follows the last row with one multiply per result after the first, and waits on any result stall
// sync active-low reset clears the sequencer, row count and zero-pivot flag
// a stalled result holds the sequencer; rows are refused until it is taken
module tridiagonal_system_solver #(
    parameter int MAX_ROWS  = tds_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = tds_pkg::FRAC_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [tds_pkg::DATA_W-1:0] s_sub_diag,
    input  logic signed [tds_pkg::DATA_W-1:0] s_diag,
    input  logic signed [tds_pkg::DATA_W-1:0] s_super_diag,
    input  logic signed [tds_pkg::DATA_W-1:0] s_rhs,
    input  logic                         s_last_row,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [tds_pkg::DATA_W-1:0] m_solution,
    output logic [tds_pkg::IDX_W-1:0]    m_row_index,
    output logic                         m_singular,
    output logic                         m_last_result
);

    localparam int DW = tds_pkg::DATA_W;
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    tds_pkg::state_t state_reg, state_next;

    // current row
    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] b_reg, b_next;
    logic [DW-1:0] c_reg, c_next;
    logic [DW-1:0] d_reg, d_next;
    logic          last_reg, last_next;
    logic [AW-1:0] idx_reg, idx_next;

    // sweep working values
    logic [DW-1:0] e_reg, e_next;
    logic [DW-1:0] nq_reg, nq_next;
    logic [DW-1:0] p_reg, p_next;
    logic [DW-1:0] q_reg, q_next;
    logic [DW-1:0] x_reg, x_next;
    logic [AW-1:0] raddr_reg, raddr_next;

    // system state
    logic [CW-1:0] rows_reg, rows_next;
    logic          pivot_reg, pivot_next;

    // result register
    logic [DW-1:0]     sol_reg, sol_next;
    logic [AW-1:0]     oidx_reg, oidx_next;
    logic              osing_reg, osing_next;

    logic          at_top;
    logic [AW-1:0] in_idx;
    logic          in_last;

    logic          mul_start, mul_done;
    logic [DW-1:0] mul_x, mul_y, mul_res;
    logic          div_start, div_done;
    logic [DW-1:0] div_mag, div_den, div_res;
    logic          div_neg;

    logic          ram_we;
    logic [DW-1:0] p_rd, q_rd;

    tds_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_ram_p (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (p_reg),
        .raddr (raddr_reg),
        .rdata (p_rd)
    );

    tds_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_ram_q (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (q_reg),
        .raddr (raddr_reg),
        .rdata (q_rd)
    );

    tds_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .done    (mul_done),
        .result  (mul_res)
    );

    tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_mag (div_mag),
        .num_neg (div_neg),
        .den     (div_den),
        .done    (div_done),
        .result  (div_res)
    );

    // the row at the top slot always closes the system
    assign at_top  = rows_reg >= CW'(MAX_ROWS - 1);
    assign in_idx  = at_top ? AW'(MAX_ROWS - 1) : rows_reg[AW-1:0];
    assign in_last = s_last_row | at_top;

    // shared unit operand selection
    always_comb begin
        mul_x = a_reg;
        mul_y = (idx_reg == '0) ? '0 : p_rd;
        if (state_reg == tds_pkg::ST_MUL2) begin
            mul_y = (idx_reg == '0) ? '0 : q_rd;
        end else if (state_reg == tds_pkg::ST_BMUL) begin
            mul_x = p_rd;
            mul_y = x_reg;
        end
        // numerator of p is -c
        div_mag = c_reg[DW-1] ? DW'(-c_reg) : c_reg;
        div_neg = !c_reg[DW-1] && (c_reg != '0);
        if (state_reg == tds_pkg::ST_DIVQ) begin
            div_mag = nq_reg[DW-1] ? DW'(-nq_reg) : nq_reg;
            div_neg = nq_reg[DW-1];
        end
        div_den = e_reg;
    end

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        e_next     = e_reg;
        nq_next    = nq_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        x_next     = x_reg;
        raddr_next = raddr_reg;
        rows_next  = rows_reg;
        pivot_next = pivot_reg;
        sol_next   = sol_reg;
        oidx_next  = oidx_reg;
        osing_next = osing_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        ram_we     = 1'b0;
        unique case (state_reg)
            tds_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    a_next     = (in_idx == '0) ? '0 : s_sub_diag;
                    b_next     = s_diag;
                    c_next     = in_last ? '0 : s_super_diag;
                    d_next     = s_rhs;
                    last_next  = in_last;
                    idx_next   = in_idx;
                    raddr_next = (in_idx == '0) ? '0 : in_idx - 1'b1;
                    state_next = tds_pkg::ST_RD;
                end
            end
            tds_pkg::ST_RD: begin
                state_next = tds_pkg::ST_MUL1;
            end
            tds_pkg::ST_MUL1: begin
                mul_start  = 1'b1;
                state_next = tds_pkg::ST_MUL1_W;
            end
            tds_pkg::ST_MUL1_W: begin
                if (mul_done) begin
                    // pivot e = b + a*p[i-1]
                    e_next = tds_pkg::sat_add({b_reg[DW-1], b_reg} + {mul_res[DW-1], mul_res});
                    state_next = tds_pkg::ST_MUL2;
                end
            end
            tds_pkg::ST_MUL2: begin
                mul_start  = 1'b1;
                state_next = tds_pkg::ST_MUL2_W;
            end
            tds_pkg::ST_MUL2_W: begin
                if (mul_done) begin
                    nq_next = tds_pkg::sat_add({d_reg[DW-1], d_reg} - {mul_res[DW-1], mul_res});
                    if (e_reg == '0) begin
                        pivot_next = 1'b1;
                        p_next     = '0;
                        q_next     = '0;
                        state_next = tds_pkg::ST_WR;
                    end else begin
                        state_next = tds_pkg::ST_DIVP;
                    end
                end
            end
            tds_pkg::ST_DIVP: begin
                div_start  = 1'b1;
                state_next = tds_pkg::ST_DIVP_W;
            end
            tds_pkg::ST_DIVP_W: begin
                if (div_done) begin
                    p_next     = div_res;
                    state_next = tds_pkg::ST_DIVQ;
                end
            end
            tds_pkg::ST_DIVQ: begin
                div_start  = 1'b1;
                state_next = tds_pkg::ST_DIVQ_W;
            end
            tds_pkg::ST_DIVQ_W: begin
                if (div_done) begin
                    q_next     = div_res;
                    state_next = tds_pkg::ST_WR;
                end
            end
            tds_pkg::ST_WR: begin
                ram_we = 1'b1;
                if (!last_reg) begin
                    rows_next  = CW'(idx_reg) + 1'b1;
                    state_next = tds_pkg::ST_IDLE;
                end else begin
                    // last unknown is q of the last row
                    x_next     = q_reg;
                    sol_next   = q_reg;
                    oidx_next  = idx_reg;
                    osing_next = pivot_reg;
                    state_next = tds_pkg::ST_EMIT;
                end
            end
            tds_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (oidx_reg == '0) begin
                        rows_next  = '0;
                        pivot_next = 1'b0;
                        state_next = tds_pkg::ST_IDLE;
                    end else begin
                        raddr_next = oidx_reg - 1'b1;
                        oidx_next  = oidx_reg - 1'b1;
                        state_next = tds_pkg::ST_BRD;
                    end
                end
            end
            tds_pkg::ST_BRD: begin
                state_next = tds_pkg::ST_BMUL;
            end
            tds_pkg::ST_BMUL: begin
                mul_start  = 1'b1;
                state_next = tds_pkg::ST_BMUL_W;
            end
            tds_pkg::ST_BMUL_W: begin
                if (mul_done) begin
                    // x[i] = p[i]*x[i+1] + q[i]
                    x_next = tds_pkg::sat_add({mul_res[DW-1], mul_res} + {q_rd[DW-1], q_rd});
                    sol_next   = x_next;
                    state_next = tds_pkg::ST_EMIT;
                end
            end
            default: begin
                state_next = tds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tds_pkg::ST_IDLE;
            rows_reg  <= '0;
            pivot_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            pivot_reg <= pivot_next;
        end
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        last_reg  <= last_next;
        idx_reg   <= idx_next;
        e_reg     <= e_next;
        nq_reg    <= nq_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        x_reg     <= x_next;
        raddr_reg <= raddr_next;
        sol_reg   <= sol_next;
        oidx_reg  <= oidx_next;
        osing_reg <= osing_next;
    end

    assign m_solution    = sol_reg;
    assign m_row_index   = tds_pkg::IDX_W'(oidx_reg);
    assign m_singular    = osing_reg;
    assign m_last_result = (oidx_reg == '0);

    // a row item shuts the input until its sweep is done
    a_row_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("row accepted while sweep busy");

    // results never overlap the input side
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("result and row ready together");

    // closing the system clears the count and the pivot flag
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_result |=> rows_reg == '0 && !pivot_reg)
        else $error("system state not cleared");

    // row count stays inside the store
    a_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_reg <= CW'(MAX_ROWS - 1))
        else $error("row count out of range");

endmodule

>>> tb/tds_checker.sv
`timescale 1ns / 100ps

module tds_checker #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [tds_pkg::DATA_W-1:0] s_sub_diag,
    input  logic signed [tds_pkg::DATA_W-1:0] s_diag,
    input  logic signed [tds_pkg::DATA_W-1:0] s_super_diag,
    input  logic signed [tds_pkg::DATA_W-1:0] s_rhs,
    input  logic                              s_last_row,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [tds_pkg::DATA_W-1:0] m_solution,
    input  logic [tds_pkg::IDX_W-1:0]         m_row_index,
    input  logic                              m_singular,
    input  logic                              m_last_result,
    output int                                errors,
    output int                                pending
);

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         idx;
        logic               sing;
        logic               fin;
    } solution_t;

    solution_t         solutions_due[$];
    logic signed [31:0] coef_p [MAX_ROWS];
    logic signed [31:0] coef_q [MAX_ROWS];
    int                 rows_taken;
    bit                 zero_pivot;

    assign pending = solutions_due.size();

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint x, input longint y);
        longint p;
        p = x * y + (64'sd1 <<< (FRAC_BITS - 1));
        return clamp32(p >>> FRAC_BITS);
    endfunction

    function automatic longint qdiv(input longint num, input longint den);
        bit       neg;
        logic [63:0] n, d, q;
        neg = (num < 0) != (den < 0);
        n = 64'(num < 0 ? -num : num) << FRAC_BITS;
        d = 64'(den < 0 ? -den : den);
        if (d == 0) return 0;
        q = (n + d / 2) / d;
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        if (neg) return -longint'(q);
        return clamp32(longint'(q));
    endfunction

    task automatic take_row(input longint a_in, input longint b, input longint c_in,
                            input longint d, input bit last_in);
        int        idx;
        longint    a, c, pp, qp, e, x;
        bit        last;
        solution_t s;
        idx = rows_taken;
        a = a_in;
        c = c_in;
        last = last_in;
        pp = 0;
        qp = 0;
        if (idx >= MAX_ROWS) idx = MAX_ROWS - 1;
        if (idx == MAX_ROWS - 1) last = 1;
        if (idx == 0) begin
            a = 0;
        end else begin
            pp = coef_p[idx-1];
            qp = coef_q[idx-1];
        end
        if (last) c = 0;
        e = clamp32(b + qmul(a, pp));
        if (e == 0) begin
            zero_pivot = 1;
            coef_p[idx] = 0;
            coef_q[idx] = 0;
        end else begin
            coef_p[idx] = 32'(qdiv(-c, e));
            coef_q[idx] = 32'(qdiv(clamp32(d - qmul(a, qp)), e));
        end
        if (!last) begin
            rows_taken = idx + 1;
            return;
        end
        x = coef_q[idx];
        for (int i = idx; i >= 0; i--) begin
            if (i != idx) x = clamp32(qmul(coef_p[i], x) + coef_q[i]);
            s.value = 32'(x);
            s.idx = 6'(i);
            s.sing = zero_pivot;
            s.fin = (i == 0);
            solutions_due = {solutions_due, s};
        end
        rows_taken = 0;
        zero_pivot = 0;
    endtask

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    initial begin
        errors = 0;
        rows_taken = 0;
        zero_pivot = 0;
    end

    always @(posedge aclk) begin
        solution_t s;
        if (aresetn && m_valid && m_ready) begin
            if (solutions_due.size() == 0) begin
                report($sformatf("unexpected result idx %0d", m_row_index));
            end else begin
                s = solutions_due.pop_front();
                if (m_solution !== s.value)
                    report($sformatf("solution idx %0d got %h want %h", s.idx,
                                     m_solution, s.value));
                if (m_row_index !== s.idx)
                    report($sformatf("row_index got %0d want %0d", m_row_index, s.idx));
                if (m_singular !== s.sing)
                    report($sformatf("singular idx %0d got %b", s.idx, m_singular));
                if (m_last_result !== s.fin)
                    report($sformatf("last_result idx %0d got %b", s.idx, m_last_result));
            end
        end
        if (aresetn && s_valid && s_ready)
            take_row(s_sub_diag, s_diag, s_super_diag, s_rhs, s_last_row);
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam longint CYCLE_LIMIT = 64'd8_000_000;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [31:0] s_sub_diag = 0;
    logic signed [31:0] s_diag = 0;
    logic signed [31:0] s_super_diag = 0;
    logic signed [31:0] s_rhs = 0;
    logic               s_last_row = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_solution;
    logic [tds_pkg::IDX_W-1:0] m_row_index;
    logic               m_singular;
    logic               m_last_result;
    int                 errors;
    int                 pending;
    longint             cycles = 0;
    bit                 quiet_phase = 0;  // no idling near the end
    bit                 hold_sink = 0;    // long receiver hold-off

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tridiagonal_system_solver test failed");
            $finish;
        end
    end

    tridiagonal_system_solver i_dut (.*);

    tds_checker i_chk (.*);

    // receiver: random stall bursts, or a long hold when asked
    initial begin
        int burst;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_ready <= 0;
                @(posedge aclk);
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 12);
                m_ready <= 0;
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1;
                @(posedge aclk);
            end
        end
    end

    // values picked to hit extremes, small magnitudes and zero often
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 0;
            3, 4: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
            default: return $urandom;
        endcase
    endfunction

    // valid stays up after the handshake; a gap before the next row or drain() takes it down
    task automatic send_row(input logic signed [31:0] a, input logic signed [31:0] b,
                            input logic signed [31:0] c, input logic signed [31:0] d,
                            input bit last);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1;
        s_sub_diag   <= a;
        s_diag       <= b;
        s_super_diag <= c;
        s_rhs        <= d;
        s_last_row   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // a system of rows: diagonal dominant so the sweep stays in range, or wild values when asked
    task automatic send_system(input int rows, input bit wild);
        logic signed [31:0] a, b, c, d;
        for (int i = 0; i < rows; i++) begin
            if (wild) begin
                a = pick_value();
                b = pick_value();
                c = pick_value();
                d = pick_value();
            end else begin
                a = $signed(32'($urandom_range(0, 32'h0002_0000))) - 32'sh0001_0000;
                c = $signed(32'($urandom_range(0, 32'h0002_0000))) - 32'sh0001_0000;
                b = 32'sh0004_0000 + 32'($urandom_range(0, 32'h0004_0000));
                if ($urandom_range(0, 1)) b = -b;
                d = $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
            end
            send_row(a, b, c, d, i == rows - 1);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int rows;
        int sent;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: one-row systems at the extremes
        send_row(32'sh7fff_ffff, 32'sh0001_0000, 32'sh7fff_ffff, 32'sh0003_0000, 1);
        send_row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 1);
        send_row(0, 32'sh7fff_ffff, 0, 32'sh8000_0000, 1);
        send_row(32'sh0, 32'sh0000_0001, 32'sh0, 32'sh7fff_ffff, 1);
        // zero pivot on a one-row and on a three-row system
        send_row(32'sh1234_5678, 0, 32'sh1111_1111, 32'sh0005_0000, 1);
        send_row(0, 0, 32'sh0001_0000, 32'sh0001_0000, 0);
        send_row(32'sh0001_0000, 32'sh0002_0000, 32'shffff_0000, 32'sh0002_0000, 0);
        send_row(32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 1);
        // pivot cancelled by sub-diagonal term
        send_row(0, 32'sh0002_0000, 32'shfffe_0000, 32'sh0001_0000, 0);
        send_row(32'sh0001_0000, 32'shffff_0000, 0, 32'sh0001_0000, 1);
        // overflowing two-row system
        send_row(0, 32'sh0000_0001, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        send_row(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 32'sh8000_0000, 1);
        // full-size system whose last row has last_row low
        for (int i = 0; i < 63; i++)
            send_row(32'sh0000_4000, 32'sh0004_0000, 32'shffff_c000, 32'sh0002_0000, 0);
        send_row(32'sh0000_8000, 32'sh0003_0000, 32'sh0000_4000, 32'sh0001_0000, 0);
        drain();

        // pressure: receiver holds off while rows keep coming
        hold_sink = 1;
        fork
            begin
                repeat (3000) @(posedge aclk);
                hold_sink = 0;
            end
            begin
                send_system(3, 0);
                send_system(2, 0);
                drain();
            end
        join
        drain();

        // random systems, mostly well-formed, some wild
        sent = 0;
        while (sent < 80) begin
            rows = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 64)
                                                : $urandom_range(1, 6);
            if (sent > 60) quiet_phase = 1;
            send_system(rows, $urandom_range(0, 4) == 0);
            sent += rows;
            if ($urandom_range(0, 7) == 0) drain();
        end

        drain();
        repeat (400) @(posedge aclk);
        if (errors == 0) begin
            $display("tridiagonal_system_solver test passed");
        end else begin
            $display("tridiagonal_system_solver test failed");
        end
        $finish;
    end

endmodule

>>> tridiagonal_system_solver.f
rtl/tds_pkg.sv
rtl/tds_ram.sv
rtl/tds_mul.sv
rtl/tds_div.sv
rtl/tridiagonal_system_solver.sv
tb/tds_checker.sv
tb/tb_top.sv
